[rtl/date_add_days_defines.svh]
// ---------------------------------------------------------------------------
// date_add_days_defines.svh
// Assertion macros used by the date_add_days checker.
// ---------------------------------------------------------------------------
`ifndef DATE_ADD_DAYS_DEFINES_SVH
`define DATE_ADD_DAYS_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define DAD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define DAD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/dad_pkg.sv]
// ---------------------------------------------------------------------------
// dad_pkg
// Types, constants and calendar helpers for the date adder.
// ---------------------------------------------------------------------------
package dad_pkg;

    localparam int MAX_YEAR   = 9999;
    localparam int YEAR_IN_W  = 14;
    localparam int MONTH_W    = 4;
    localparam int DAY_W      = 5;
    localparam int OFFSET_W   = 17;
    localparam int STATUS_W   = 2;
    localparam int D_W        = OFFSET_W + 1;
    localparam int YEAR_RAW_W = $clog2(MAX_YEAR + 2);
    localparam int YEAR_W     = (YEAR_RAW_W > YEAR_IN_W) ? YEAR_RAW_W : YEAR_IN_W;
    localparam int IN_DATA_W  = YEAR_IN_W + MONTH_W + DAY_W + OFFSET_W;
    localparam int OUT_RAW_W  = YEAR_IN_W + MONTH_W + DAY_W;
    localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

    localparam int CYCLE_400  = 400;

    localparam logic [MONTH_W-1:0] JAN = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] FEB = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] APR = MONTH_W'(4);
    localparam logic [MONTH_W-1:0] JUN = MONTH_W'(6);
    localparam logic [MONTH_W-1:0] SEP = MONTH_W'(9);
    localparam logic [MONTH_W-1:0] NOV = MONTH_W'(11);
    localparam logic [MONTH_W-1:0] DEC = MONTH_W'(12);

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_BAD_DATE = 2'd1,
        ST_CLAMPED  = 2'd2
    } t_status;

    typedef struct packed {
        logic load;
        logic mod_step;
        logic check;
        logic step;
    } t_dp_cmd;

    typedef struct packed {
        logic mod_done;
        logic run_done;
    } t_dp_sts;

    // leap from the year reduced modulo 400
    function automatic logic is_leap(input logic [YEAR_W-1:0] y400);
        logic d4;
        logic century;
        d4      = (y400[1:0] == 2'b00);
        century = (y400 == YEAR_W'(100)) || (y400 == YEAR_W'(200)) ||
                  (y400 == YEAR_W'(300));
        return d4 && !century;
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                   input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        if (m < JAN || m > DEC) begin
            len = DAY_W'(0);
        end else if (m == APR || m == JUN || m == SEP || m == NOV) begin
            len = DAY_W'(30);
        end else if (m == FEB) begin
            len = leap ? DAY_W'(29) : DAY_W'(28);
        end else begin
            len = DAY_W'(31);
        end
        return len;
    endfunction

endpackage

[rtl/date_add_days.sv]
// One word is in flight at a time; a new word is taken only once the
//   result of the last one has been handed over.
// The month walk steps one month per cycle through the step unit.
// Reset: synchronous active-low i_rst_n returns the controller to idle with
//   no output word pending; date registers are not reset.
// ---------------------------------------------------------------------------
// date_add_days
// Gregorian date plus a signed day offset, walked month by month.
// ---------------------------------------------------------------------------
module date_add_days import dad_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input word
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // [13:0] year_in, [17:14] month_in, [22:18] day_in, [39:23] day_offset
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // result word
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // [13:0] year_out, [17:14] month_out, [22:18] day_out, [23] zero pad
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    // [1:0] status: 0 ok, 1 invalid input date, 2 year clamped
    output logic [STATUS_W-1:0]   o_m_tuser
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Controller: idle -> load -> reduce year mod 400 (one subtract a cycle)
    // -> validate date -> walk one month a cycle -> hold result until taken.
    dad_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .i_out_ready (i_m_tready),
        .i_sts       (sts),
        .o_in_ready  (o_s_tready),
        .o_out_valid (o_m_tvalid),
        .o_cmd       (cmd)
    );

    // Datapath: the year mod 400 remainder is kept alongside the year so the
    // leap rule never needs a divider; it wraps as the walk crosses years.
    dad_dp u_dp (
        .i_clk    (i_clk),
        .i_cmd    (cmd),
        .i_data   (i_s_tdata),
        .o_sts    (sts),
        .o_data   (o_m_tdata),
        .o_status (o_m_tuser)
    );

endmodule

[rtl/dad_dp.sv]
// ---------------------------------------------------------------------------
// dad_dp
// Datapath: date registers, mod-400 reduction and the one-month step unit.
// ---------------------------------------------------------------------------
module dad_dp import dad_pkg::*; (
    input  logic                  i_clk,
    input  t_dp_cmd               i_cmd,
    input  logic [IN_DATA_W-1:0]  i_data,
    output t_dp_sts               o_sts,
    output logic [OUT_DATA_W-1:0] o_data,
    output logic [STATUS_W-1:0]   o_status
);

    logic [YEAR_W-1:0]       r_year,   n_year;
    logic [YEAR_W-1:0]       r_y400,   n_y400;
    logic [MONTH_W-1:0]      r_month,  n_month;
    logic [DAY_W-1:0]        r_day;
    logic signed [D_W-1:0]   r_d,      n_d;
    t_status                 r_status, n_status;

    logic [YEAR_IN_W-1:0]    in_year;
    logic [MONTH_W-1:0]      in_month;
    logic [DAY_W-1:0]        in_day;
    logic [OFFSET_W-1:0]     in_off;

    logic                    leap;
    logic                    leap_prev;
    logic [YEAR_W-1:0]       y400_dec;
    logic [DAY_W-1:0]        cur_len;
    logic signed [D_W-1:0]   cur_len_s;
    logic                    fits;
    logic                    bad;

    assign in_year  = i_data[YEAR_IN_W-1:0];
    assign in_month = i_data[YEAR_IN_W +: MONTH_W];
    assign in_day   = i_data[YEAR_IN_W+MONTH_W +: DAY_W];
    assign in_off   = i_data[YEAR_IN_W+MONTH_W+DAY_W +: OFFSET_W];

    assign leap      = is_leap(r_y400);
    assign y400_dec  = (r_y400 == '0) ? YEAR_W'(CYCLE_400 - 1) : r_y400 - YEAR_W'(1);
    assign leap_prev = is_leap(y400_dec);
    assign cur_len   = month_len(leap, r_month);
    assign cur_len_s = $signed({{(D_W-DAY_W){1'b0}}, cur_len});
    assign fits      = (r_d >= $signed(D_W'(1))) && (r_d <= cur_len_s);

    assign bad = (r_year < YEAR_W'(1)) || (r_year > YEAR_W'(MAX_YEAR)) ||
                 (r_month < JAN) || (r_month > DEC) ||
                 (r_day < DAY_W'(1)) || (r_day > cur_len);

    always_comb begin
        n_year   = r_year;
        n_y400   = r_y400;
        n_month  = r_month;
        n_d      = r_d;
        n_status = r_status;
        if (i_cmd.load) begin
            n_year   = YEAR_W'(in_year);
            n_y400   = YEAR_W'(in_year);
            n_month  = in_month;
            n_d      = $signed({{(D_W-DAY_W){1'b0}}, in_day}) +
                       $signed({in_off[OFFSET_W-1], in_off});
            n_status = ST_OK;
        end else if (i_cmd.mod_step) begin
            if (r_y400 >= YEAR_W'(CYCLE_400)) begin
                n_y400 = r_y400 - YEAR_W'(CYCLE_400);
            end
        end else if (i_cmd.check) begin
            if (bad) begin
                n_status = ST_BAD_DATE;
            end
        end else if (i_cmd.step && r_status == ST_OK && !fits) begin
            if (r_d > cur_len_s) begin
                // forward one month
                n_d = r_d - cur_len_s;
                if (r_month == DEC) begin
                    n_month = JAN;
                    n_year  = r_year + YEAR_W'(1);
                    n_y400  = (r_y400 == YEAR_W'(CYCLE_400 - 1)) ? '0 :
                              r_y400 + YEAR_W'(1);
                    if (r_year >= YEAR_W'(MAX_YEAR)) begin
                        n_year   = YEAR_W'(MAX_YEAR);
                        n_month  = DEC;
                        n_d      = $signed(D_W'(31));
                        n_status = ST_CLAMPED;
                    end
                end else begin
                    n_month = r_month + MONTH_W'(1);
                end
            end else begin
                // backward one month
                if (r_month <= JAN) begin
                    if (r_year <= YEAR_W'(1)) begin
                        n_year   = YEAR_W'(1);
                        n_month  = JAN;
                        n_d      = $signed(D_W'(1));
                        n_status = ST_CLAMPED;
                    end else begin
                        n_month = DEC;
                        n_year  = r_year - YEAR_W'(1);
                        n_y400  = y400_dec;
                        n_d     = r_d + $signed({{(D_W-DAY_W){1'b0}},
                                                 month_len(leap_prev, DEC)});
                    end
                end else begin
                    n_month = r_month - MONTH_W'(1);
                    n_d     = r_d + $signed({{(D_W-DAY_W){1'b0}},
                                             month_len(leap, r_month - MONTH_W'(1))});
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_year   <= n_year;
        r_y400   <= n_y400;
        r_month  <= n_month;
        r_d      <= n_d;
        r_status <= n_status;
        if (i_cmd.load) begin
            r_day <= in_day;
        end
    end

    assign o_sts.mod_done = (r_y400 < YEAR_W'(CYCLE_400));
    assign o_sts.run_done = (r_status != ST_OK) || fits;

    always_comb begin
        o_data = '0;
        if (r_status != ST_BAD_DATE) begin
            o_data[YEAR_IN_W-1:0]                 = r_year[YEAR_IN_W-1:0];
            o_data[YEAR_IN_W +: MONTH_W]          = r_month;
            o_data[YEAR_IN_W+MONTH_W +: DAY_W]    = r_d[DAY_W-1:0];
        end
    end
    assign o_status = r_status;

endmodule

[rtl/dad_ctrl.sv]
// ---------------------------------------------------------------------------
// dad_ctrl
// Controller: sequences load, mod-400 reduce, check, month walk and output.
// ---------------------------------------------------------------------------
module dad_ctrl import dad_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MOD   = 5'b00010,
        S_CHECK = 5'b00100,
        S_RUN   = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MOD;
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_sts.mod_done) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = S_RUN;
            end
            S_RUN: begin
                o_cmd.step = 1'b1;
                if (i_sts.run_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

endmodule

[rtl/dad_checker.sv]
// ---------------------------------------------------------------------------
// dad_checker
// Port-level assertions for date_add_days, bound to the top level.
// ---------------------------------------------------------------------------
`include "date_add_days_defines.svh"

module dad_checker import dad_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_tvalid,
    input logic                  o_s_tready,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [OUT_DATA_W-1:0] o_m_tdata,
    input logic [STATUS_W-1:0]   o_m_tuser
);

    `DAD_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser), "result word changed while stalled")
    `DAD_ASSERT_NXT(a_no_fast, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_m_tvalid && !o_s_tready, "result or ready right after accept")
    `DAD_ASSERT_NOW(a_one, i_clk, i_rst_n, o_m_tvalid, !o_s_tready, "input ready while result pending")
    `DAD_ASSERT_NOW(a_bad_zero, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser == ST_BAD_DATE), o_m_tdata == '0, "invalid date result not zero")
    `DAD_ASSERT_NOW(a_range, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser != ST_BAD_DATE), (o_m_tdata[17:14] >= JAN) && (o_m_tdata[17:14] <= DEC) && (o_m_tdata[22:18] != '0), "result date out of range")

endmodule

bind date_add_days dad_checker u_dad_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

[bench/tb.sv]
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for date_add_days. A short directed table covers
// calendar edges, invalid dates and year clamping. A random run follows,
// mostly valid dates with random offsets and some raw noise words. Each
// accepted result is checked against a hand-typed result or a calendar walk kept in the bench.
// ---------------------------------------------------------------------------
module tb;
    import dad_pkg::*;

    localparam int DIR_WORDS  = 25;
    localparam int RAND_WORDS = 245;
    localparam int QUIET_MAX  = 25000;  // covers the worst walk plus stalls
    localparam int DRAIN_WAIT = 40;
    localparam int PAUSE_AT   = 120;    // random word index where the sender drains

    // one input word, unpacked
    typedef struct packed {
        logic [YEAR_IN_W-1:0]       year;
        logic [MONTH_W-1:0]         month;
        logic [DAY_W-1:0]           day;
        logic signed [OFFSET_W-1:0] ofs;
    } t_date_in;

    // one result word, unpacked
    typedef struct packed {
        logic [YEAR_IN_W-1:0] year;
        logic [MONTH_W-1:0]   month;
        logic [DAY_W-1:0]     day;
        t_status              status;
    } t_date_out;

    // directed row: stimulus plus a hand-written result where 'typed' is set
    typedef struct packed {
        t_date_in  stim;
        logic      typed;
        t_date_out want;
    } t_dir_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    // [13:0] year_in, [17:14] month_in, [22:18] day_in, [39:23] day_offset
    logic [IN_DATA_W-1:0]  i_s_tdata;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    // [13:0] year_out, [17:14] month_out, [22:18] day_out, [23] zero pad
    logic [OUT_DATA_W-1:0] o_m_tdata;
    // [1:0] status
    logic [STATUS_W-1:0]   o_m_tuser;

    t_date_out due_dates[$];   // results owed by the block, oldest first
    t_date_out pending_date;   // result of the word now on the input bus
    int        mismatches;
    int        burst_left;

    wire s_fire = i_s_tvalid && o_s_tready;
    wire m_fire = o_m_tvalid && i_m_tready;

    // Directed rows. Typed results: zero offset, calendar edges, invalid
    // dates, clamping at both ends. Rows with typed = 0 use the predictor.
    t_dir_row dir_rows [DIR_WORDS] = '{
        '{'{14'd2024, 4'd1,  5'd1,  17'sd0},     1'b1, '{14'd2024, 4'd1,  5'd1,  ST_OK}},
        '{'{14'd2023, 4'd12, 5'd31, 17'sd1},     1'b1, '{14'd2024, 4'd1,  5'd1,  ST_OK}},
        '{'{14'd2024, 4'd1,  5'd1,  -17'sd1},    1'b1, '{14'd2023, 4'd12, 5'd31, ST_OK}},
        '{'{14'd2024, 4'd2,  5'd28, 17'sd1},     1'b1, '{14'd2024, 4'd2,  5'd29, ST_OK}},
        '{'{14'd1900, 4'd2,  5'd28, 17'sd1},     1'b1, '{14'd1900, 4'd3,  5'd1,  ST_OK}},
        '{'{14'd2000, 4'd2,  5'd28, 17'sd1},     1'b1, '{14'd2000, 4'd2,  5'd29, ST_OK}},
        '{'{14'd2024, 4'd4,  5'd30, 17'sd1},     1'b1, '{14'd2024, 4'd5,  5'd1,  ST_OK}},
        // invalid input dates
        '{'{14'd2024, 4'd2,  5'd30, 17'sd0},     1'b1, '{14'd0, 4'd0, 5'd0, ST_BAD_DATE}},
        '{'{14'd2023, 4'd2,  5'd29, 17'sd5},     1'b1, '{14'd0, 4'd0, 5'd0, ST_BAD_DATE}},
        '{'{14'd2024, 4'd0,  5'd1,  17'sd1},     1'b1, '{14'd0, 4'd0, 5'd0, ST_BAD_DATE}},
        '{'{14'd2024, 4'd13, 5'd1,  17'sd1},     1'b1, '{14'd0, 4'd0, 5'd0, ST_BAD_DATE}},
        '{'{14'd2024, 4'd15, 5'd31, 17'sd1},     1'b1, '{14'd0, 4'd0, 5'd0, ST_BAD_DATE}},
        '{'{14'd2024, 4'd5,  5'd0,  17'sd1},     1'b1, '{14'd0, 4'd0, 5'd0, ST_BAD_DATE}},
        '{'{14'd0,    4'd1,  5'd1,  17'sd1},     1'b1, '{14'd0, 4'd0, 5'd0, ST_BAD_DATE}},
        '{'{14'd10000, 4'd1, 5'd1,  17'sd0},     1'b1, '{14'd0, 4'd0, 5'd0, ST_BAD_DATE}},
        '{'{14'd16383, 4'd12, 5'd31, -17'sd1},   1'b1, '{14'd0, 4'd0, 5'd0, ST_BAD_DATE}},
        // year range ends
        '{'{14'd9999, 4'd12, 5'd31, 17'sd0},     1'b1, '{14'd9999, 4'd12, 5'd31, ST_OK}},
        '{'{14'd1,    4'd1,  5'd1,  17'sd0},     1'b1, '{14'd1,    4'd1,  5'd1,  ST_OK}},
        '{'{14'd9999, 4'd12, 5'd31, 17'sd1},     1'b1, '{14'd9999, 4'd12, 5'd31, ST_CLAMPED}},
        '{'{14'd1,    4'd1,  5'd1,  -17'sd1},    1'b1, '{14'd1,    4'd1,  5'd1,  ST_CLAMPED}},
        '{'{14'd9999, 4'd1,  5'd1,  17'sd65535}, 1'b1, '{14'd9999, 4'd12, 5'd31, ST_CLAMPED}},
        '{'{14'd1,    4'd12, 5'd31, -17'sd65535}, 1'b1, '{14'd1,   4'd1,  5'd1,  ST_CLAMPED}},
        // longest walks, both directions, incl. the most negative offset code
        '{'{14'd5000, 4'd6,  5'd15, 17'sd65535}, 1'b0, '{14'd0, 4'd0, 5'd0, ST_OK}},
        '{'{14'd5000, 4'd6,  5'd15, -17'sd65535}, 1'b0, '{14'd0, 4'd0, 5'd0, ST_OK}},
        '{'{14'd5000, 4'd6,  5'd15, 17'h10000},  1'b0, '{14'd0, 4'd0, 5'd0, ST_OK}}
    };

    date_add_days DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // Gregorian month length; 0 for a month code outside 1..12
    function automatic int days_in_month(input int y, input int m);
        logic leap;
        leap = ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
        if (m < JAN || m > DEC) begin
            return 0;
        end else if (m == APR || m == JUN || m == SEP || m == NOV) begin
            return 30;
        end else if (m == FEB) begin
            return leap ? 29 : 28;
        end
        return 31;
    endfunction

    // Walk the calendar one month at a time, forward then backward.
    function automatic t_date_out add_days(input t_date_in w);
        t_date_out r;
        int y;
        int m;
        int d;
        r = '0;
        r.status = ST_OK;
        y = w.year;
        m = w.month;
        if (y < 1 || y > MAX_YEAR || m < JAN || m > DEC ||
            w.day < 1 || w.day > days_in_month(y, m)) begin
            r.status = ST_BAD_DATE;
            return r;
        end
        d = int'(w.day) + int'(w.ofs);
        while (r.status == ST_OK && d > days_in_month(y, m)) begin
            d -= days_in_month(y, m);
            m++;
            if (m > DEC) begin
                m = JAN;
                y++;
                if (y > MAX_YEAR) begin
                    // ran off the top: pin to the last day
                    y = MAX_YEAR;
                    m = DEC;
                    d = 31;
                    r.status = ST_CLAMPED;
                end
            end
        end
        while (r.status == ST_OK && d < 1) begin
            if (m <= JAN) begin
                if (y <= 1) begin
                    // ran off the bottom: pin to the first day
                    y = 1;
                    m = JAN;
                    d = 1;
                    r.status = ST_CLAMPED;
                    break;
                end
                m = DEC;
                y--;
            end else begin
                m--;
            end
            d += days_in_month(y, m);
        end
        r.year  = y[YEAR_IN_W-1:0];
        r.month = m[MONTH_W-1:0];
        r.day   = d[DAY_W-1:0];
        return r;
    endfunction

    // Random word: mostly valid dates (some at the year range ends, many at
    // month end), offsets mostly small, a fifth over the full 17-bit range.
    // About one word in eight is raw noise on every field.
    function automatic t_date_in pick_date();
        t_date_in w;
        int sel;
        int len;
        sel = $urandom_range(0, 99);
        if (sel < 12) begin
            w.year  = YEAR_IN_W'($urandom);
            w.month = MONTH_W'($urandom);
            w.day   = DAY_W'($urandom);
            w.ofs   = OFFSET_W'($urandom);
            return w;
        end
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            w.year = YEAR_IN_W'($urandom_range(1, 3));
        end else if (sel == 1) begin
            w.year = YEAR_IN_W'($urandom_range(MAX_YEAR - 3, MAX_YEAR));
        end else begin
            w.year = YEAR_IN_W'($urandom_range(1, MAX_YEAR));
        end
        w.month = MONTH_W'($urandom_range(1, 12));
        len = days_in_month(w.year, w.month);
        w.day = ($urandom_range(0, 3) == 0) ? DAY_W'(len) : DAY_W'($urandom_range(1, len));
        sel = $urandom_range(0, 99);
        if (sel < 8) begin
            w.ofs = OFFSET_W'(int'($urandom_range(0, 2)) - 1);
        end else if (sel < 55) begin
            w.ofs = OFFSET_W'(int'($urandom_range(0, 800)) - 400);
        end else if (sel < 80) begin
            w.ofs = OFFSET_W'(int'($urandom_range(0, 10000)) - 5000);
        end else begin
            w.ofs = OFFSET_W'($urandom);
        end
        return w;
    endfunction

    // Present one word and hold it until accepted. Entered just after a
    // falling edge; returns just after the falling edge that follows the
    // accepting rising edge.
    task automatic send_date(input t_date_in w, input t_date_out want);
        i_s_tvalid   <= 1'b1;
        i_s_tdata    <= {w.ofs, w.day, w.month, w.year};
        pending_date  = want;
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
    endtask

    // Burst pacing: keep valid high inside a burst, drop it for a random
    // gap between bursts.
    task automatic pace_sender();
        int gap;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    // Stop sending until the block has handed back every owed result.
    task automatic drain_sender();
        i_s_tvalid <= 1'b0;
        do @(negedge i_clk); while (due_dates.size() != 0);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Result side: ready in spans of always-on, coin-flip, or mostly stalled.
    initial begin : result_sink
        int mode;
        int span;
        i_m_tready = 1'b0;
        forever begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(16, 300);
            repeat (span) begin
                @(negedge i_clk);
                case (mode)
                    0:       i_m_tready <= 1'b1;
                    1:       i_m_tready <= 1'($urandom_range(0, 1));
                    default: i_m_tready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // Scoreboard: log an expectation per accepted input word, compare each
    // accepted result word with the oldest one.
    always @(posedge i_clk) begin
        t_date_out want;
        if (i_rst_n && s_fire) begin
            due_dates.push_back(pending_date);
        end
        if (i_rst_n && m_fire) begin
            if (due_dates.size() == 0) begin
                $error("unexpected result word: tdata %h tuser %h", o_m_tdata, o_m_tuser);
                mismatches++;
            end else begin
                want = due_dates.pop_front();
                if (o_m_tdata[13:0] !== want.year) begin
                    $error("year_out: expected %0d, got %0d", want.year, o_m_tdata[13:0]);
                    mismatches++;
                end
                if (o_m_tdata[17:14] !== want.month) begin
                    $error("month_out: expected %0d, got %0d", want.month, o_m_tdata[17:14]);
                    mismatches++;
                end
                if (o_m_tdata[22:18] !== want.day) begin
                    $error("day_out: expected %0d, got %0d", want.day, o_m_tdata[22:18]);
                    mismatches++;
                end
                if (o_m_tdata[OUT_DATA_W-1:23] !== '0) begin
                    $error("pad: expected 0, got %0d", o_m_tdata[OUT_DATA_W-1:23]);
                    mismatches++;
                end
                if (o_m_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_m_tuser);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: too long with no word moving on either side ends the run.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_MAX) begin
            @(posedge i_clk);
            if (s_fire || m_fire) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb: errors");
        $finish;
    end

    initial begin : stimulus
        t_date_in  w;
        t_date_out want;
        mismatches   = 0;
        burst_left   = 1;
        pending_date = '0;
        i_rst_n      = 1'b0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table
        for (int i = 0; i < DIR_WORDS; i++) begin
            w    = dir_rows[i].stim;
            want = dir_rows[i].typed ? dir_rows[i].want : add_days(w);
            send_date(w, want);
            pace_sender();
        end
        // let everything come back before the random part
        drain_sender();

        // random part, with one full drain partway through
        for (int i = 0; i < RAND_WORDS; i++) begin
            w = pick_date();
            send_date(w, add_days(w));
            if (i == PAUSE_AT) begin
                drain_sender();
            end else if (i == RAND_WORDS - 1) begin
                i_s_tvalid <= 1'b0;
            end else begin
                pace_sender();
            end
        end

        // wait out the last results, then keep watching for strays
        while (due_dates.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
